// ----- rtl/i2cmbe_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
// Used by the front decoder, the word queue, the bus sequencer and the top level.
`default_nettype none

package i2cmbe_pkg;

   // Operation codes carried on the request channel.
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_START     = 3'd1;
   localparam logic [2:0] OP_STOP      = 3'd2;
   localparam logic [2:0] OP_SEND      = 3'd3;
   localparam logic [2:0] OP_READ_ACK  = 3'd4;
   localparam logic [2:0] OP_READ_NACK = 3'd5;

   localparam logic [7:0] MSB_MASK      = 8'h80;
   localparam logic [7:0] TIMEOUT_RESET = 8'd200;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_START,
      KIND_STOP,
      KIND_SEND,
      KIND_READ_ACK,
      KIND_READ_NACK
   } kind_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] tx_byte;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       sda_is_input;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       no_ack;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] tx_byte;
      logic       sda_sample;
   } item_type;

endpackage

`default_nettype wire

// ----- rtl/i2cmbe_front.sv -----
// Front end of the I2C master byte engine: classifies request words.
// Depends on i2cmbe_pkg for the request and classified item types.
`default_nettype none

module i2cmbe_front (
   input  wire  i2cmbe_pkg::req_type  req_payload,
   output i2cmbe_pkg::item_type       item
);

   // Unknown operation codes behave as plain ticks.
   always_comb begin
      item.tx_byte    = req_payload.tx_byte;
      item.sda_sample = req_payload.sda_sample;
      case (req_payload.operation)
         i2cmbe_pkg::OP_START:     item.kind = i2cmbe_pkg::KIND_START;
         i2cmbe_pkg::OP_STOP:      item.kind = i2cmbe_pkg::KIND_STOP;
         i2cmbe_pkg::OP_SEND:      item.kind = i2cmbe_pkg::KIND_SEND;
         i2cmbe_pkg::OP_READ_ACK:  item.kind = i2cmbe_pkg::KIND_READ_ACK;
         i2cmbe_pkg::OP_READ_NACK: item.kind = i2cmbe_pkg::KIND_READ_NACK;
         default:                  item.kind = i2cmbe_pkg::KIND_TICK;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/i2cmbe_queue.sv -----
// Short word queue between the front decoder and the bus sequencer.
// Depends on i2cmbe_pkg for the item type and the queue depth.
`default_nettype none

module i2cmbe_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire  i2cmbe_pkg::item_type push_item,
   output logic                       full,
   input  wire                        pop,
   output logic                       pop_valid,
   output i2cmbe_pkg::item_type       pop_item
);

   localparam logic [i2cmbe_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      i2cmbe_pkg::QUEUE_PTR_W'(i2cmbe_pkg::QUEUE_DEPTH - 1);
   localparam logic [i2cmbe_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      i2cmbe_pkg::QUEUE_CNT_W'(i2cmbe_pkg::QUEUE_DEPTH);

   i2cmbe_pkg::item_type                 slot_ff [i2cmbe_pkg::QUEUE_DEPTH];
   logic [i2cmbe_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [i2cmbe_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [i2cmbe_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                                 do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/i2cmbe_back.sv -----
// Back end of the I2C master byte engine: the half-bit bus sequencer and
// its result register. Depends on i2cmbe_pkg for item and result types.
`default_nettype none

module i2cmbe_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire  [7:0]                 csr_wr_data,
   input  wire                        item_valid,
   input  wire  i2cmbe_pkg::item_type item,
   output logic                       item_pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output i2cmbe_pkg::rsp_type        rsp_payload
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_TXL, PH_TXH,
      PH_AKL, PH_AKW, PH_RXL, PH_RXH, PH_RAL, PH_RAH
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic                 ack_sel_ff, ack_sel_in;
   logic [7:0]           shift_ff, shift_in;
   logic [3:0]           bit_count_ff, bit_count_in;
   logic [7:0]           wait_count_ff, wait_count_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 ack_flag_ff, ack_flag_in;
   logic [7:0]           rx_hold_ff, rx_hold_in;
   logic [7:0]           timeout_ff;
   logic                 done;
   logic                 rsp_valid_ff, rsp_valid_in;
   i2cmbe_pkg::rsp_type  rsp_ff, rsp_in;

   // One word per cycle moves whenever the result register is free or drains.
   assign item_pop    = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      phase_in      = phase_ff;
      ack_sel_in    = ack_sel_ff;
      shift_in      = shift_ff;
      bit_count_in  = bit_count_ff;
      wait_count_in = wait_count_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_flag_in   = ack_flag_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;

      if (phase_ff == PH_IDLE && item.kind != i2cmbe_pkg::KIND_TICK) begin
         case (item.kind)
            i2cmbe_pkg::KIND_START: begin
               sda_in   = 1'b1;
               scl_in   = 1'b1;
               phase_in = PH_ST1;
            end
            i2cmbe_pkg::KIND_STOP: begin
               sda_in   = 1'b0;
               phase_in = PH_SP1;
            end
            i2cmbe_pkg::KIND_SEND: begin
               shift_in     = item.tx_byte;
               bit_count_in = '0;
               scl_in       = 1'b0;
               sda_in       = |(item.tx_byte & i2cmbe_pkg::MSB_MASK);
               phase_in     = PH_TXL;
            end
            default: begin
               ack_sel_in   = (item.kind == i2cmbe_pkg::KIND_READ_ACK);
               shift_in     = '0;
               bit_count_in = '0;
               scl_in       = 1'b0;
               sda_in       = 1'b1;
               phase_in     = PH_RXL;
            end
         endcase
      end else begin
         case (phase_ff)
            PH_ST1: begin
               sda_in   = 1'b0;
               phase_in = PH_ST2;
            end
            PH_ST2: begin
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            PH_SP1: begin
               scl_in   = 1'b1;
               phase_in = PH_SP2;
            end
            PH_SP2: begin
               sda_in   = 1'b1;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            PH_TXL: begin
               scl_in   = 1'b1;
               phase_in = PH_TXH;
            end
            PH_TXH: begin
               scl_in       = 1'b0;
               bit_count_in = bit_count_ff + 4'd1;
               shift_in     = {shift_ff[6:0], 1'b0};
               if (bit_count_in < i2cmbe_pkg::BITS_PER_BYTE) begin
                  sda_in   = |(shift_in & i2cmbe_pkg::MSB_MASK);
                  phase_in = PH_TXL;
               end else begin
                  sda_in   = 1'b1;
                  phase_in = PH_AKL;
               end
            end
            PH_AKL: begin
               scl_in        = 1'b1;
               wait_count_in = '0;
               phase_in      = PH_AKW;
            end
            PH_AKW: begin
               if (!item.sda_sample) begin
                  ack_flag_in = 1'b0;
                  scl_in      = 1'b0;
                  phase_in    = PH_IDLE;
                  done        = 1'b1;
               end else begin
                  wait_count_in = wait_count_ff + 8'd1;
                  if (wait_count_in >= timeout_ff) begin
                     ack_flag_in = 1'b1;
                     scl_in      = 1'b0;
                     phase_in    = PH_IDLE;
                     done        = 1'b1;
                  end
               end
            end
            PH_RXL: begin
               scl_in   = 1'b1;
               phase_in = PH_RXH;
            end
            PH_RXH: begin
               shift_in     = {shift_ff[6:0], item.sda_sample};
               scl_in       = 1'b0;
               bit_count_in = bit_count_ff + 4'd1;
               if (bit_count_in < i2cmbe_pkg::BITS_PER_BYTE) begin
                  phase_in = PH_RXL;
               end else begin
                  sda_in   = !ack_sel_ff;
                  phase_in = PH_RAL;
               end
            end
            PH_RAL: begin
               scl_in   = 1'b1;
               phase_in = PH_RAH;
            end
            PH_RAH: begin
               scl_in     = 1'b0;
               rx_hold_in = shift_ff;
               phase_in   = PH_IDLE;
               done       = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      rsp_in.scl_level    = scl_in;
      rsp_in.sda_drive    = sda_in;
      rsp_in.sda_is_input = phase_in inside {PH_AKL, PH_AKW, PH_RXL, PH_RXH};
      rsp_in.busy_res     = (phase_in != PH_IDLE);
      rsp_in.done_res     = done;
      rsp_in.rx_byte      = rx_hold_in;
      rsp_in.no_ack       = ack_flag_in;

      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         ack_sel_ff    <= 1'b0;
         shift_ff      <= '0;
         bit_count_ff  <= '0;
         wait_count_ff <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_flag_ff   <= 1'b0;
         rx_hold_ff    <= '0;
         timeout_ff    <= i2cmbe_pkg::TIMEOUT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            phase_ff      <= phase_in;
            ack_sel_ff    <= ack_sel_in;
            shift_ff      <= shift_in;
            bit_count_ff  <= bit_count_in;
            wait_count_ff <= wait_count_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            ack_flag_ff   <= ack_flag_in;
            rx_hold_ff    <= rx_hold_in;
         end
      end
      if (item_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/i2c_master_byte_engine_unit.sv -----
// Top level of the I2C master byte engine: front decoder, word queue and
// bus sequencer. Depends on i2cmbe_pkg and the three i2cmbe_* modules.
//
// Usage: every request word is either a command (start, stop, send byte,
// read with ACK, read with NACK) or a tick that advances the bus by one
// half-bit phase and carries the sampled SDA level. A command is acted on
// only while the sequencer is idle; otherwise it counts as a tick. Every
// request word yields exactly one response word with the SCL and SDA line
// levels, the SDA direction, busy and done flags, the last received byte
// and the no-acknowledge flag.
// The acknowledge timeout is written through csr_wr_en and csr_wr_data and
// resets to 200 ticks.
// A word accepted on the request side passes through the queue slot and then the
// sequencer's result register before it can be taken from the response side.
// Throughput: one word per cycle while the receiver does not stall; each word is one
// small state update in the sequencer, and the output register lets the next word
// enter in the same cycle that a waiting result is taken.
// When the receiver stalls, the result register holds, the sequencer stops,
// and the two-entry queue fills; req_stall rises once it is full.
// Reset (synchronous, active high) empties the queue, clears the result
// register and returns the bus to idle with SCL and SDA released high.
`default_nettype none

module i2c_master_byte_engine_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  i2cmbe_pkg::req_type  req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output i2cmbe_pkg::rsp_type        rsp_payload,
   input  wire                        csr_wr_en,
   input  wire  [7:0]                 csr_wr_data
);

   i2cmbe_pkg::item_type  front_item;
   i2cmbe_pkg::item_type  queue_item;
   logic                  queue_full;
   logic                  queue_valid;
   logic                  queue_pop;

   // The queue accepts a word whenever it has room, independent of the
   // sequencer, so the request side only sees the queue occupancy.
   assign req_stall = queue_full;

   i2cmbe_front u_front (
      .req_payload (req_payload),
      .item        (front_item)
   );

   i2cmbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_item  (queue_item)
   );

   // The sequencer pops one word per cycle whenever its result register
   // is empty or being drained in the same cycle.
   i2cmbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (queue_valid),
      .item        (queue_item),
      .item_pop    (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- test/i2c_master_byte_engine_unit_tb.sv -----
// Self-checking testbench for i2c_master_byte_engine_unit: drives command and tick words,
// tracks the expected SCL/SDA line behavior in a scoreboard class and checks every response.
// Depends on i2cmbe_pkg and the engine RTL only.
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit_tb;
   import i2cmbe_pkg::*;

   // Operation codes the engine does not define; it must treat them as ticks.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // An acknowledge delay longer than any timeout, so the slave never answers.
   localparam int NEVER_ACK = 1000;
   localparam int WORDS_PER_PHASE = 16;
   localparam int HOLD_CYCLES = 60;

   // Bus phases of the tracker. Each name says what the next tick will do.
   typedef enum logic [3:0] {
      BUS_IDLE,
      START_SDA_FALL,
      START_SCL_FALL,
      STOP_SCL_RISE,
      STOP_SDA_RISE,
      TX_BIT_LOW,
      TX_BIT_HIGH,
      ACK_SETUP,
      ACK_WAIT,
      RX_BIT_LOW,
      RX_BIT_HIGH,
      REPLY_LOW,
      REPLY_HIGH
   } bus_phase_type;

   // The tracker follows the line sequencer word by word and keeps the expected
   // response words in order. It also counts every mismatch and prints the first 40.
   class i2c_line_tracker;
      bus_phase_type phase;
      logic [2:0] active_cmd;
      logic [7:0] shift_byte;
      logic [3:0] bits_done;
      logic [7:0] high_samples;
      logic       scl_line;
      logic       sda_line;
      logic       missed_ack;
      logic [7:0] last_rx;
      logic [7:0] ack_limit;
      rsp_type    expected_lines[$];
      int         errors;
      int         words;
      int         checked;
      int         sequences;
      int         timeouts;

      function new();
         phase = BUS_IDLE;
         active_cmd = OP_TICK;
         shift_byte = '0;
         bits_done = '0;
         high_samples = '0;
         scl_line = 1'b1;
         sda_line = 1'b1;
         missed_ack = 1'b0;
         last_rx = '0;
         ack_limit = TIMEOUT_RESET;
         errors = 0;
         words = 0;
         checked = 0;
         sequences = 0;
         timeouts = 0;
      endfunction

      function void set_ack_limit(input logic [7:0] value);
         ack_limit = value;
      endfunction

      function bit busy();
         return phase != BUS_IDLE;
      endfunction

      function bit awaiting_ack();
         return phase == ACK_WAIT;
      endfunction

      function bit sampling_data();
         return phase == RX_BIT_HIGH;
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction

      // Advances the tracked bus by one accepted request word.
      function void note_request(input req_type w);
         rsp_type want;
         logic    done;
         done = 1'b0;
         words++;
         if (phase == BUS_IDLE && w.operation >= OP_START && w.operation <= OP_READ_NACK) begin
            active_cmd = w.operation;
            case (w.operation)
               OP_START: begin
                  sda_line = 1'b1;
                  scl_line = 1'b1;
                  phase = START_SDA_FALL;
               end
               OP_STOP: begin
                  sda_line = 1'b0;
                  phase = STOP_SCL_RISE;
               end
               OP_SEND: begin
                  shift_byte = w.tx_byte;
                  bits_done = '0;
                  scl_line = 1'b0;
                  sda_line = shift_byte[7];
                  phase = TX_BIT_LOW;
               end
               default: begin
                  shift_byte = '0;
                  bits_done = '0;
                  scl_line = 1'b0;
                  sda_line = 1'b1;
                  phase = RX_BIT_LOW;
               end
            endcase
         end else begin
            // Ticks, unknown codes and commands issued while busy all land here.
            case (phase)
               START_SDA_FALL: begin
                  sda_line = 1'b0;
                  phase = START_SCL_FALL;
               end
               START_SCL_FALL: begin
                  scl_line = 1'b0;
                  phase = BUS_IDLE;
                  done = 1'b1;
               end
               STOP_SCL_RISE: begin
                  scl_line = 1'b1;
                  phase = STOP_SDA_RISE;
               end
               STOP_SDA_RISE: begin
                  sda_line = 1'b1;
                  phase = BUS_IDLE;
                  done = 1'b1;
               end
               TX_BIT_LOW: begin
                  scl_line = 1'b1;
                  phase = TX_BIT_HIGH;
               end
               TX_BIT_HIGH: begin
                  scl_line = 1'b0;
                  bits_done = bits_done + 4'd1;
                  shift_byte = shift_byte << 1;
                  if (bits_done < BITS_PER_BYTE) begin
                     sda_line = shift_byte[7];
                     phase = TX_BIT_LOW;
                  end else begin
                     sda_line = 1'b1;
                     phase = ACK_SETUP;
                  end
               end
               ACK_SETUP: begin
                  scl_line = 1'b1;
                  high_samples = '0;
                  phase = ACK_WAIT;
               end
               ACK_WAIT: begin
                  if (!w.sda_sample) begin
                     missed_ack = 1'b0;
                     scl_line = 1'b0;
                     phase = BUS_IDLE;
                     done = 1'b1;
                  end else begin
                     high_samples = high_samples + 8'd1;
                     if (high_samples >= ack_limit) begin
                        missed_ack = 1'b1;
                        scl_line = 1'b0;
                        phase = BUS_IDLE;
                        done = 1'b1;
                        timeouts++;
                     end
                  end
               end
               RX_BIT_LOW: begin
                  scl_line = 1'b1;
                  phase = RX_BIT_HIGH;
               end
               RX_BIT_HIGH: begin
                  shift_byte = {shift_byte[6:0], w.sda_sample};
                  scl_line = 1'b0;
                  bits_done = bits_done + 4'd1;
                  if (bits_done < BITS_PER_BYTE) begin
                     phase = RX_BIT_LOW;
                  end else begin
                     sda_line = (active_cmd == OP_READ_ACK) ? 1'b0 : 1'b1;
                     phase = REPLY_LOW;
                  end
               end
               REPLY_LOW: begin
                  scl_line = 1'b1;
                  phase = REPLY_HIGH;
               end
               REPLY_HIGH: begin
                  scl_line = 1'b0;
                  last_rx = shift_byte;
                  phase = BUS_IDLE;
                  done = 1'b1;
               end
               default: begin
                  phase = BUS_IDLE;
               end
            endcase
         end
         if (done) sequences++;
         want.scl_level = scl_line;
         want.sda_drive = sda_line;
         want.sda_is_input = (phase == ACK_SETUP || phase == ACK_WAIT ||
                              phase == RX_BIT_LOW || phase == RX_BIT_HIGH);
         want.busy_res = (phase != BUS_IDLE);
         want.done_res = done;
         want.rx_byte = last_rx;
         want.no_ack = missed_ack;
         expected_lines.push_back(want);
      endfunction

      task report(input string what);
         errors++;
         if (errors <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_response(input rsp_type got);
         rsp_type want;
         checked++;
         if (expected_lines.size() == 0) begin
            report($sformatf("response word %0d arrived with nothing expected", checked));
            return;
         end
         want = expected_lines.pop_front();
         if (got.scl_level !== want.scl_level)
            report($sformatf("word %0d scl_level %b, expected %b", checked, got.scl_level,
                             want.scl_level));
         if (got.sda_drive !== want.sda_drive)
            report($sformatf("word %0d sda_drive %b, expected %b", checked, got.sda_drive,
                             want.sda_drive));
         if (got.sda_is_input !== want.sda_is_input)
            report($sformatf("word %0d sda_is_input %b, expected %b", checked, got.sda_is_input,
                             want.sda_is_input));
         if (got.busy_res !== want.busy_res)
            report($sformatf("word %0d busy_res %b, expected %b", checked, got.busy_res,
                             want.busy_res));
         if (got.done_res !== want.done_res)
            report($sformatf("word %0d done_res %b, expected %b", checked, got.done_res,
                             want.done_res));
         if (got.rx_byte !== want.rx_byte)
            report($sformatf("word %0d rx_byte %h, expected %h", checked, got.rx_byte,
                             want.rx_byte));
         if (got.no_ack !== want.no_ack)
            report($sformatf("word %0d no_ack %b, expected %b", checked, got.no_ack,
                             want.no_ack));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_payload;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_payload;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   i2c_line_tracker tracker = new();

   // Knobs shared between the sender, the receiver and the sequence below.
   bit offering = 1'b0;
   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   bit hold_request = 1'b0;
   int settings_used = 0;

   always #5 clock = ~clock;

   i2c_master_byte_engine_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Every response word taken at a clock edge is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_response(rsp_payload);
   end

   // Receiver: short random stall bursts, or one long hold-off when asked for. The long
   // hold lets the queue inside the engine fill so that req_stall has to rise.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Hard stop in case the handshake ever hangs.
   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic req_type make_word(input logic [2:0] op, input logic [7:0] tx_value,
                                         input logic sda);
      req_type w;
      w.operation = op;
      w.tx_byte = tx_value;
      w.sda_sample = sda;
      return w;
   endfunction

   // Lowers valid once; a second call in the same time step does nothing.
   task automatic stop_offering();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Offers one word, optionally after a short gap, and waits until the engine takes it.
   // Valid stays high afterwards so that back-to-back words need no extra assignment.
   task automatic send_word(input req_type w);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         stop_offering();
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_payload <= w;
      if (!offering) begin
         req_valid <= 1'b1;
         offering = 1'b1;
      end
      do @(posedge clock); while (req_stall);
      tracker.note_request(w);
   endtask

   task automatic wait_for_results();
      stop_offering();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // The timeout register is only written with the bus idle and nothing in flight.
   task automatic write_ack_limit(input logic [7:0] value);
      wait_for_results();
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_ack_limit(value);
      settings_used++;
   endtask

   // Runs one command to completion. read_bits is what the slave returns on a read,
   // MSB first; ack_delay is how many high samples the slave gives before pulling SDA low.
   // With noise on, some ticks are replaced by commands or unknown codes, which the
   // engine must treat as plain ticks while it is busy.
   task automatic run_command(input logic [2:0] op, input logic [7:0] tx_value,
                              input logic [7:0] read_bits, input int ack_delay,
                              input bit noisy);
      req_type    w;
      logic [7:0] bits_left;
      int         high_count;
      bits_left = read_bits;
      high_count = 0;
      send_word(make_word(op, tx_value, 1'($urandom_range(0, 1))));
      while (tracker.busy()) begin
         w.operation = OP_TICK;
         if (noisy && $urandom_range(0, 9) == 0)
            w.operation = 3'($urandom_range(OP_START, OP_SPARE_7));
         w.tx_byte = 8'($urandom);
         if (tracker.awaiting_ack()) begin
            w.sda_sample = (high_count >= ack_delay) ? 1'b0 : 1'b1;
            high_count++;
         end else if (tracker.sampling_data()) begin
            w.sda_sample = bits_left[7];
            bits_left = bits_left << 1;
         end else begin
            w.sda_sample = 1'($urandom_range(0, 1));
         end
         send_word(w);
      end
   endtask

   // One random transaction, sometimes preceded by a stray tick or unknown code on an idle bus.
   task automatic random_transaction();
      int delay;
      if ($urandom_range(0, 7) == 0)
         send_word(make_word(($urandom_range(0, 1) != 0) ? OP_TICK
                                : 3'($urandom_range(OP_SPARE_6, OP_SPARE_7)),
                             8'($urandom), 1'($urandom_range(0, 1))));
      delay = ($urandom_range(0, 3) == 0) ? NEVER_ACK : $urandom_range(0, 8);
      run_command(3'($urandom_range(OP_START, OP_READ_NACK)), 8'($urandom), 8'($urandom),
                  delay, 1'b1);
   endtask

   initial begin
      int           phase_end;
      int           guard;
      logic [7:0]   limits[6];

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset timeout of 200.
      // Ticks and unknown codes on an idle bus change nothing.
      send_word(make_word(OP_TICK, 8'h00, 1'b0));
      send_word(make_word(OP_SPARE_6, 8'hFF, 1'b1));
      send_word(make_word(OP_SPARE_7, 8'h00, 1'b0));
      run_command(OP_START, 8'h00, 8'h00, 0, 1'b0);
      // A start whose remaining phases are driven by a send command and an unknown code,
      // both of which must be ignored as commands while the bus is busy.
      send_word(make_word(OP_START, 8'hFF, 1'b1));
      send_word(make_word(OP_SEND, 8'hC3, 1'b0));
      send_word(make_word(OP_SPARE_7, 8'h3C, 1'b1));
      run_command(OP_SEND, 8'hFF, 8'h00, 0, 1'b0);
      run_command(OP_SEND, 8'h00, 8'h00, 3, 1'b0);
      run_command(OP_READ_ACK, 8'h00, 8'hFF, 0, 1'b0);
      run_command(OP_READ_NACK, 8'hFF, 8'h00, 0, 1'b0);
      run_command(OP_STOP, 8'h00, 8'h00, 0, 1'b0);
      // The slave answers on the last sample before the timeout, then never answers.
      run_command(OP_SEND, 8'h5A, 8'h00, TIMEOUT_RESET - 1, 1'b0);
      run_command(OP_SEND, 8'hA5, 8'h00, NEVER_ACK, 1'b0);
      // A read leaves the no-acknowledge flag as it was.
      run_command(OP_READ_NACK, 8'h00, 8'hA5, 0, 1'b0);

      // Shortest timeout: one high sample ends the wait; an early ack still clears the flag.
      write_ack_limit(8'd1);
      run_command(OP_SEND, 8'h81, 8'h00, NEVER_ACK, 1'b0);
      run_command(OP_SEND, 8'h7E, 8'h00, 0, 1'b0);
      // A zero timeout behaves like one.
      write_ack_limit(8'd0);
      run_command(OP_SEND, 8'h01, 8'h00, NEVER_ACK, 1'b0);
      // Longest timeout, answered at the last moment and then left to run out.
      write_ack_limit(8'd255);
      run_command(OP_SEND, 8'h80, 8'h00, 254, 1'b0);
      run_command(OP_SEND, 8'h55, 8'h00, NEVER_ACK, 1'b0);

      // Random part: several timeout settings, mostly short so that timeouts are common.
      limits[0] = 8'd2;
      limits[1] = 8'd1;
      limits[2] = 8'($urandom_range(3, 16));
      limits[3] = 8'd255;
      limits[4] = 8'($urandom_range(1, 255));
      limits[5] = 8'($urandom_range(1, 12));
      for (int p = 0; p < 6; p++) begin
         write_ack_limit(limits[p]);
         // Gaps stop for the last setting so that the engine also runs at full rate.
         if (p == 5) begin
            sender_gaps = 1'b0;
            receiver_gaps = 1'b0;
         end
         // Long receiver hold while words keep coming.
         if (p == 2) hold_request = 1'b1;
         phase_end = tracker.words + WORDS_PER_PHASE;
         while (tracker.words < phase_end) begin
            random_transaction();
            // Now and then the sender pauses until every response is back.
            if (p == 1 && $urandom_range(0, 15) == 0) wait_for_results();
         end
      end

      // Drain what is still in flight, then allow for the pipeline latency.
      stop_offering();
      guard = 0;
      while (tracker.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d response words never arrived", tracker.pending()));
      repeat (8) @(posedge clock);

      $display("Covered %0d request words and %0d finished bus sequences, %0d of them sends",
               tracker.words, tracker.sequences, tracker.timeouts);
      $display("that timed out, over %0d timeout settings with stalls, holds and pauses.",
               settings_used);
      if (tracker.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
